/* hdl/swmf_pkg.sv */
// Shared types for the sliding window median filter.
// No dependencies; used by swmf_cell and sliding_window_median_filter.
`default_nettype none

package swmf_pkg;

   // Flags a cell hands to the cell above it in the sorted row.
   typedef struct packed {
      logic removed;       // the oldest sample sits in this cell or below it
      logic sample_above;  // the new sample lands above this cell
   } swmf_link_type;

endpackage

`default_nettype wire

/* hdl/sliding_window_median_filter.sv */
// Top level of the sliding window median filter: sorted cell row and output register.
// Depends on swmf_pkg and swmf_cell.
`default_nettype none

// Running median over the last WINDOW_SIZE signed samples. The window starts
// as all zeros after reset, so early results count those zeros. The samples
// are kept in a row of cells in sorted order, each tagged with its age; a
// new sample removes the oldest one and is inserted at its sorted place in
// the same cycle. One sample is taken per cycle unless a pending result is
// held at the result channel; the output register takes its median from the
// updated cells. The insert path is set by the removal flag rippling up the
// row of cells, so its depth grows with WINDOW_SIZE. For an even window the
// result is the mean of the two middle samples, truncated toward zero.
module sliding_window_median_filter
   import swmf_pkg::*;
#(
   parameter int WINDOW_SIZE = 5,
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   // [SAMPLE_WIDTH-1:0] sample; upper pad bits ignored
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   // [SAMPLE_WIDTH-1:0] median; upper pad bits zero
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int AGE_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int MID = WINDOW_SIZE / 2;

   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic signed [SAMPLE_WIDTH-1:0] cell_val [WINDOW_SIZE];
   logic [AGE_W-1:0]               cell_age [WINDOW_SIZE];
   logic [WINDOW_SIZE-1:0]         cell_greater;
   swmf_link_type                  link [WINDOW_SIZE];
   logic [WINDOW_SIZE-1:0]         order_ok;

   logic                           pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] median_ff;
   logic signed [SAMPLE_WIDTH-1:0] median_now;
   logic                           out_free;
   logic                           load_out;
   logic                           req_xfer;

   assign sample = req_tdata[SAMPLE_WIDTH-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_out = pend_ff && out_free;
   assign req_tready = !pend_ff || out_free;
   assign req_xfer = req_tvalid && req_tready;

   genvar g;
   generate
      for (g = 0; g < WINDOW_SIZE; g++) begin : g_cell
         logic signed [SAMPLE_WIDTH-1:0] val_below, val_above;
         logic [AGE_W-1:0]               age_below, age_above;
         logic                           greater_above;
         swmf_link_type                  link_below;

         if (g == 0) begin : g_bottom
            assign val_below = '0;
            assign age_below = '0;
            assign link_below = '0;
         end else begin : g_inner_below
            assign val_below = cell_val[g-1];
            assign age_below = cell_age[g-1];
            assign link_below = link[g-1];
         end

         if (g == WINDOW_SIZE - 1) begin : g_top
            assign val_above = '0;
            assign age_above = '0;
            assign greater_above = 1'b1;
            assign order_ok[g] = 1'b1;
         end else begin : g_inner_above
            assign val_above = cell_val[g+1];
            assign age_above = cell_age[g+1];
            assign greater_above = cell_greater[g+1];
            assign order_ok[g] = (cell_val[g] <= cell_val[g+1]);
         end

         swmf_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH),
            .AGE_W(AGE_W),
            .AGE_OLDEST(AGE_W'(WINDOW_SIZE - 1)),
            .RESET_AGE(AGE_W'(g)),
            .IS_FIRST(g == 0),
            .IS_LAST(g == WINDOW_SIZE - 1)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .load(req_xfer),
            .sample(sample),
            .val_below(val_below),
            .age_below(age_below),
            .link_below(link_below),
            .val_above(val_above),
            .age_above(age_above),
            .greater_above(greater_above),
            .val_q(cell_val[g]),
            .age_q(cell_age[g]),
            .greater(cell_greater[g]),
            .link_up(link[g])
         );
      end

      if (WINDOW_SIZE % 2 == 1) begin : g_odd
         assign median_now = cell_val[MID];
      end else begin : g_even
         logic signed [SAMPLE_WIDTH:0] pair_sum, pair_adj;
         // Adding the sign bit before the shift rounds a negative mean toward zero.
         assign pair_sum = {cell_val[MID-1][SAMPLE_WIDTH-1], cell_val[MID-1]}
                         + {cell_val[MID][SAMPLE_WIDTH-1], cell_val[MID]};
         assign pair_adj = pair_sum + {{SAMPLE_WIDTH{1'b0}}, pair_sum[SAMPLE_WIDTH]};
         assign median_now = pair_adj[SAMPLE_WIDTH:1];
      end
   endgenerate

   always_comb begin
      pend_in = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         pend_in = 1'b0;
      end
      if (req_xfer) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         median_ff <= median_now;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = TDATA_W'($unsigned(median_ff));

`ifndef ASSERT_OFF
   // Exactly one cell holds the oldest sample, so the removal flag reaches the top.
   a_oldest_present: assert property (@(posedge clock) disable iff (reset)
      link[WINDOW_SIZE-1].removed)
      else $error("no cell holds the oldest sample");

   a_row_sorted: assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("cell row is out of order");

   a_xfer_pends: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> pend_ff)
      else $error("accepted sample left no pending result");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_tvalid)
      else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

/* hdl/swmf_cell.sv */
// One cell of the sorted sample row: holds one sample and its age.
// Depends on swmf_pkg for the link struct between neighboring cells.
`default_nettype none

module swmf_cell
   import swmf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24,
   parameter int AGE_W = 3,
   parameter logic [AGE_W-1:0] AGE_OLDEST = '0,
   parameter logic [AGE_W-1:0] RESET_AGE = '0,
   parameter bit IS_FIRST = 1'b0,
   parameter bit IS_LAST = 1'b0
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            load,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
   input  wire logic signed [SAMPLE_WIDTH-1:0] val_below,
   input  wire logic [AGE_W-1:0]          age_below,
   input  wire swmf_link_type             link_below,
   input  wire logic signed [SAMPLE_WIDTH-1:0] val_above,
   input  wire logic [AGE_W-1:0]          age_above,
   input  wire logic                      greater_above,
   output logic signed [SAMPLE_WIDTH-1:0] val_q,
   output logic [AGE_W-1:0]               age_q,
   output logic                           greater,
   output swmf_link_type                  link_up
);

   logic signed [SAMPLE_WIDTH-1:0] val_ff, val_in;
   logic [AGE_W-1:0]               age_ff, age_in;
   logic                           removed;
   logic                           sample_above;
   logic                           take_new;

   assign greater = (val_ff > sample);
   assign removed = (IS_FIRST ? 1'b0 : link_below.removed) | (age_ff == AGE_OLDEST);

   // After the oldest sample drops out, the cells above it slide down by one.
   // This position then stays below the new sample when its compacted value
   // is not greater than the sample.
   assign sample_above = !IS_LAST && (removed ? !greater_above : !greater);
   assign take_new = IS_FIRST ? 1'b1 : link_below.sample_above;

   assign link_up.removed = removed;
   assign link_up.sample_above = sample_above;

   always_comb begin
      val_in = val_ff;
      age_in = age_ff;
      if (sample_above) begin
         if (removed) begin
            val_in = val_above;
            age_in = age_above + AGE_W'(1);
         end else begin
            val_in = val_ff;
            age_in = age_ff + AGE_W'(1);
         end
      end else if (take_new) begin
         val_in = sample;
         age_in = '0;
      end else if (link_below.removed) begin
         val_in = val_ff;
         age_in = age_ff + AGE_W'(1);
      end else begin
         val_in = val_below;
         age_in = age_below + AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         age_ff <= RESET_AGE;
      end else if (load) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign val_q = val_ff;
   assign age_q = age_ff;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking bench for the sliding window median filter: stream driver,
// result monitor and a window-of-five median predictor.
// Depends on sliding_window_median_filter.
`default_nettype none

module testbench;

   localparam int WIN = 5;
   localparam int SW = 24;
   localparam int DW = ((SW + 7) / 8) * 8;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int TAIL_CYCLES = 16;
   localparam int MAX_REPORTS = 10;

   typedef enum int {
      PACE_FREE,
      PACE_SRC_IDLE,
      PACE_SNK_STALL,
      PACE_BOTH
   } pace_mode_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;    // [SW-1:0] sample
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;         // [SW-1:0] median

   sliding_window_median_filter #(
      .WINDOW_SIZE(WIN),
      .SAMPLE_WIDTH(SW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   pace_mode_type pace = PACE_FREE;
   logic [DW-1:0] sample_queue[$];
   logic [DW-1:0] median_queue[$];
   logic req_taken = 1'b0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int error_count = 0;
   int samples_sent = 0;
   int medians_checked = 0;

   // Predictor state: the circular window and its write slot.
   logic signed [SW-1:0] pred_window[WIN];
   int unsigned pred_wr_pos;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d medians still expected.", median_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void clear_window();
      for (int i = 0; i < WIN; i++) begin
         pred_window[i] = '0;
      end
      pred_wr_pos = 0;
   endfunction

   // Writes the sample over the oldest slot and returns the window median.
   function automatic logic signed [SW-1:0] insert_and_median(logic signed [SW-1:0] sample);
      logic signed [SW-1:0] sorted[WIN];
      logic signed [SW-1:0] key;
      longint pair_sum;
      int j;
      if (pred_wr_pos >= WIN) pred_wr_pos = 0;
      pred_window[pred_wr_pos] = sample;
      pred_wr_pos = (pred_wr_pos + 1 >= WIN) ? 0 : pred_wr_pos + 1;
      for (int i = 0; i < WIN; i++) begin
         sorted[i] = pred_window[i];
      end
      for (int i = 1; i < WIN; i++) begin
         key = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = key;
      end
      if (WIN % 2 == 0) begin
         pair_sum = longint'(sorted[WIN / 2 - 1]) + longint'(sorted[WIN / 2]);
         return SW'(pair_sum / 2);
      end
      return sorted[WIN / 2];
   endfunction

   function automatic logic [SW-1:0] random_sample();
      case ($urandom_range(9))
         0: return {1'b0, {(SW - 1){1'b1}}};
         1: return {1'b1, {(SW - 1){1'b0}}};
         2, 3: return SW'($signed($urandom_range(32)) - 16);
         4: return {$urandom_range(1) == 1, {(SW - 5){$urandom_range(1) == 1}},
                    4'($urandom)};
         default: return SW'($urandom);
      endcase
   endfunction

   function automatic bit sender_idles();
      if (pace == PACE_SRC_IDLE) return $urandom_range(99) < 58;
      if (pace == PACE_BOTH) return $urandom_range(99) < 24;
      return 1'b0;
   endfunction

   function automatic bit receiver_stalls();
      if (pace == PACE_SNK_STALL) return $urandom_range(99) < 58;
      if (pace == PACE_BOTH) return $urandom_range(99) < 24;
      return 1'b0;
   endfunction

   // Driver: a new sample goes out only once the previous one has transferred.
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (sample_queue.size() > 0 && !sender_idles()) begin
            req_tdata <= sample_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver ready, with a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !receiver_stalls();
      end
   end

   // Monitor: predicts on each input transfer, checks each result transfer.
   always @(posedge clock) begin
      logic [DW-1:0] want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            median_queue.push_back(DW'(insert_and_median(req_tdata[SW-1:0])));
            samples_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (median_queue.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("Unexpected median %h with nothing pending.", rsp_tdata);
            end else begin
               want = median_queue.pop_front();
               medians_checked++;
               if (rsp_tdata !== want) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("Median %0d mismatch: expected %h, got %h.",
                              medians_checked, want, rsp_tdata);
               end
            end
         end
      end
   end

   task automatic wait_drained();
      while (sample_queue.size() > 0 || req_tvalid || median_queue.size() > 0)
         @(posedge clock);
   endtask

   task automatic run_random(pace_mode_type mode, int count);
      @(posedge clock);
      pace = mode;
      for (int i = 0; i < count; i++) begin
         sample_queue.push_back(DW'(random_sample()));
      end
      wait_drained();
   endtask

   initial begin
      logic [SW-1:0] directed[$];
      clear_window();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Early samples meet the start-up zeros, then come the field extremes, ties and sign changes.
      directed = '{SW'(1), SW'(-1), {1'b0, {(SW - 1){1'b1}}}, {1'b1, {(SW - 1){1'b0}}},
                   SW'(0), {1'b0, {(SW - 1){1'b1}}}, {1'b0, {(SW - 1){1'b1}}},
                   {1'b1, {(SW - 1){1'b0}}}, {1'b1, {(SW - 1){1'b0}}},
                   {1'b1, {(SW - 1){1'b0}}}, SW'(-2), SW'(2), SW'(-1), SW'(1), SW'(0),
                   SW'(7), SW'(7), SW'(7), SW'(-7), SW'(-7), {SW{1'b1}}, SW'(24'h555555),
                   SW'(24'haaaaaa), SW'(100), SW'(-100)};
      @(posedge clock);
      pace = PACE_FREE;
      foreach (directed[i]) begin
         sample_queue.push_back(DW'(directed[i]));
      end
      wait_drained();

      run_random(PACE_FREE, 90);
      run_random(PACE_SRC_IDLE, 90);
      run_random(PACE_SNK_STALL, 90);
      run_random(PACE_BOTH, 90);

      // Result side held off while the sender keeps offering.
      @(posedge clock);
      pace = PACE_FREE;
      hold_requests++;
      for (int i = 0; i < 40; i++) begin
         sample_queue.push_back(DW'(random_sample()));
      end
      wait_drained();

      run_random(PACE_BOTH, 50);

      repeat (TAIL_CYCLES) @(posedge clock);
      error_count += median_queue.size();
      $display("Covered %0d samples and %0d checked medians over free-running,",
               samples_sent, medians_checked);
      $display("sender-idle, receiver-stall, mixed and long hold-off phases.");
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures.", error_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
hdl/swmf_pkg.sv
hdl/swmf_cell.sv
hdl/sliding_window_median_filter.sv
tb/sv/testbench.sv
